// ===== src/alist_pkg.sv =====
// shared types and constants for the array list core
// no dependencies; imported by every module of the core but alist_ram
package alist_pkg;

    localparam int ALIST_DEPTH = 32;
    localparam int OP_W        = 2;
    localparam int POS_W       = 7;
    localparam int VAL_W       = 32;
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 1;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_DUMP   = 2'd3
    } alist_op_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd;
        logic wr_shift;
        logic wr_item;
        logic cnt_inc;
        logic cnt_dec;
        logic set_ok;
        logic idx_inc;
        logic out_status;
        logic out_elem;
    } alist_cmd_t;

    // datapath to controller
    typedef struct packed {
        alist_op_t op;
        logic      ins_ok;
        logic      del_ok;
        logic      ins_nomove;
        logic      cnt_zero;
        logic      shift_last;
        logic      scan_last;
        logic      hit;
        logic      out_free;
    } alist_sts_t;

endpackage

// ===== src/array_list_insert_delete_search_core.sv =====
// top level of the array list core: stream ports, controller and datapath
// depends on alist_pkg, alist_ctrl, alist_dp and alist_ram
//
// Ordered list of up to DEPTH signed 32-bit values held in a simple dual-port
// ram with an element count. Each input transaction is one operation: insert
// at a position (later elements move up), delete at a position (later elements
// move down), search for a value, or dump the whole list. Insert, delete and
// search give one result transaction with status_ok, tlast high and no element;
// a failed insert (position beyond the count or list full), a delete beyond the
// last element and a search miss report status_ok low and leave the list as is.
// A dump gives one transaction per element in list order, tlast on the final
// one; a dump of an empty list gives a single transaction with no element.
// Items are taken one at a time. The store has one registered read port, so
// every element moved, compared or emitted is read first and then written,
// compared or output in a separate state after the read. A finished result
// waits in an output register, so the next item is taken while it is still
// pending on the master side. The store is not cleared at reset; only entries
// below the count are ever read.
module array_list_insert_delete_search_core #(
    parameter int DEPTH = alist_pkg::ALIST_DEPTH  // 2 to 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input transactions
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [alist_pkg::IN_TDATA_W-1:0]    s_tdata,   // position[6:0], item_value[38:7]
    input  logic [alist_pkg::IN_TUSER_W-1:0]    s_tuser,   // opcode[1:0]
    // result transactions
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [alist_pkg::OUT_TDATA_W-1:0]   m_tdata,   // status_ok[0], element[32:1]
    output logic [alist_pkg::OUT_TUSER_W-1:0]   m_tuser,   // element_valid[0]
    output logic                                m_tlast    // is_last
);
    import alist_pkg::*;

    alist_cmd_t       cmd;
    alist_sts_t       sts;
    logic             out_status_ok;
    logic [VAL_W-1:0] out_element;
    logic             out_element_valid;

    // controller: sequences the element walk of each operation
    alist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: store, count, walk index and result register
    alist_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .in_op             (alist_op_t'(s_tuser[OP_W-1:0])),
        .in_pos            (s_tdata[POS_W-1:0]),
        .in_val            (s_tdata[POS_W+VAL_W-1:POS_W]),
        .out_ready         (m_tready),
        .out_valid         (m_tvalid),
        .out_status_ok     (out_status_ok),
        .out_element       (out_element),
        .out_element_valid (out_element_valid),
        .out_is_last       (m_tlast)
    );

    // pack result fields, zero pad up to whole bytes
    assign m_tdata = {{(OUT_TDATA_W-VAL_W-1){1'b0}}, out_element, out_status_ok};
    assign m_tuser = out_element_valid;

    // status-only results always close the operation
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("result without element not marked last");

    // status-only results carry a zero element
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[VAL_W:1] == '0)
        else $error("result without element has nonzero element field");

    // dumped elements always report success
    a_elem_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[0])
        else $error("dumped element without status_ok");

    // one item at a time: no acceptance in the cycle right after one
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while previous operation still running");

endmodule

// ===== src/alist_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module alist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/alist_dp.sv =====
// datapath of the array list core: element store, count, walk index, result register
// depends on alist_pkg and alist_ram
module alist_dp #(
    parameter int DEPTH = alist_pkg::ALIST_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  alist_pkg::alist_cmd_t         cmd,
    output alist_pkg::alist_sts_t         sts,
    input  alist_pkg::alist_op_t          in_op,
    input  logic [alist_pkg::POS_W-1:0]   in_pos,
    input  logic [alist_pkg::VAL_W-1:0]   in_val,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_status_ok,
    output logic [alist_pkg::VAL_W-1:0]   out_element,
    output logic                          out_element_valid,
    output logic                          out_is_last
);
    import alist_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IW    = CNT_W + 1;

    alist_op_t          op_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [VAL_W-1:0]   val_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               ok_reg, ok_next;

    logic               ovalid_reg, ovalid_next;
    logic               ook_reg;
    logic [VAL_W-1:0]   oelem_reg;
    logic               oevalid_reg;
    logic               olast_reg;

    logic [CNT_W-1:0]   rd_idx;
    logic [AW-1:0]      waddr;
    logic [VAL_W-1:0]   wdata;
    logic [VAL_W-1:0]   rdata;
    logic               we;
    logic [POS_W-1:0]   cnt_pos;
    logic [IW-1:0]      idx_w;
    logic [IW-1:0]      cnt_w;

    assign cnt_pos = POS_W'(cnt_reg);
    assign idx_w   = IW'(idx_reg);
    assign cnt_w   = IW'(cnt_reg);

    // neighbor read address depends on the shift direction
    always_comb
    begin
        case (op_reg)
            OP_INSERT: rd_idx = idx_reg - CNT_W'(1);
            OP_DELETE: rd_idx = idx_reg + CNT_W'(1);
            default:   rd_idx = idx_reg;
        endcase
    end

    assign we    = cmd.wr_shift | cmd.wr_item;
    assign waddr = cmd.wr_item ? pos_reg[AW-1:0] : idx_reg[AW-1:0];
    assign wdata = cmd.wr_item ? val_reg : rdata;

    alist_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd),
        .raddr (rd_idx[AW-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        sts.op         = op_reg;
        sts.ins_ok     = (pos_reg <= cnt_pos) && (cnt_w != IW'(DEPTH));
        sts.del_ok     = pos_reg < cnt_pos;
        sts.ins_nomove = cnt_pos == pos_reg;
        sts.cnt_zero   = cnt_reg == '0;
        sts.scan_last  = (idx_w + IW'(1)) >= cnt_w;
        if (op_reg == OP_INSERT)
        begin
            sts.shift_last = ({1'b0, POS_W'(idx_reg)} == ({1'b0, pos_reg} + (POS_W+1)'(1)));
        end
        else
        begin
            sts.shift_last = (idx_w + IW'(2)) >= cnt_w;
        end
        sts.hit      = rdata == val_reg;
        sts.out_free = !ovalid_reg || out_ready;
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            case (in_op)
                OP_INSERT: idx_next = cnt_reg;
                OP_DELETE: idx_next = CNT_W'(in_pos);
                default:   idx_next = '0;
            endcase
        end
        else if (cmd.wr_shift)
        begin
            idx_next = (op_reg == OP_INSERT) ? idx_reg - CNT_W'(1) : idx_reg + CNT_W'(1);
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        ok_next = ok_reg;
        if (cmd.load)
        begin
            ok_next = 1'b0;
        end
        else if (cmd.set_ok)
        begin
            ok_next = 1'b1;
        end
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (cmd.out_status || cmd.out_elem)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            ok_reg     <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            ok_reg     <= ok_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load)
        begin
            op_reg  <= in_op;
            pos_reg <= in_pos;
            val_reg <= in_val;
        end
        if (cmd.out_status)
        begin
            ook_reg     <= ok_reg;
            oelem_reg   <= '0;
            oevalid_reg <= 1'b0;
            olast_reg   <= 1'b1;
        end
        else if (cmd.out_elem)
        begin
            ook_reg     <= 1'b1;
            oelem_reg   <= rdata;
            oevalid_reg <= 1'b1;
            olast_reg   <= sts.scan_last;
        end
    end

    assign out_valid         = ovalid_reg;
    assign out_status_ok     = ook_reg;
    assign out_element       = oelem_reg;
    assign out_element_valid = oevalid_reg;
    assign out_is_last       = olast_reg;

endmodule

// ===== src/alist_ctrl.sv =====
// controller state machine of the array list core
// depends on alist_pkg
module alist_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  alist_pkg::alist_sts_t sts,
    output alist_pkg::alist_cmd_t cmd
);
    import alist_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SH_RD,
        ST_SH_WR,
        ST_INS_WR,
        ST_DEC,
        ST_SR_RD,
        ST_SR_CMP,
        ST_DP_RD,
        ST_DP_EMIT,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                case (sts.op)
                    OP_INSERT:
                    begin
                        if (!sts.ins_ok)
                            state_next = ST_RESULT;
                        else if (sts.ins_nomove)
                            state_next = ST_INS_WR;
                        else
                            state_next = ST_SH_RD;
                    end
                    OP_DELETE:
                    begin
                        if (!sts.del_ok)
                            state_next = ST_RESULT;
                        else if (sts.scan_last)
                            state_next = ST_DEC;
                        else
                            state_next = ST_SH_RD;
                    end
                    OP_SEARCH:
                    begin
                        state_next = sts.cnt_zero ? ST_RESULT : ST_SR_RD;
                    end
                    OP_DUMP:
                    begin
                        if (sts.cnt_zero)
                        begin
                            cmd.set_ok = 1'b1;
                            state_next = ST_RESULT;
                        end
                        else
                        begin
                            state_next = ST_DP_RD;
                        end
                    end
                    default: state_next = ST_RESULT;
                endcase
            end
            ST_SH_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_SH_WR;
            end
            ST_SH_WR:
            begin
                cmd.wr_shift = 1'b1;
                if (sts.shift_last)
                    state_next = (sts.op == OP_INSERT) ? ST_INS_WR : ST_DEC;
                else
                    state_next = ST_SH_RD;
            end
            ST_INS_WR:
            begin
                cmd.wr_item = 1'b1;
                cmd.cnt_inc = 1'b1;
                cmd.set_ok  = 1'b1;
                state_next  = ST_RESULT;
            end
            ST_DEC:
            begin
                cmd.cnt_dec = 1'b1;
                cmd.set_ok  = 1'b1;
                state_next  = ST_RESULT;
            end
            ST_SR_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_SR_CMP;
            end
            ST_SR_CMP:
            begin
                if (sts.hit)
                begin
                    cmd.set_ok = 1'b1;
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = sts.scan_last ? ST_RESULT : ST_SR_RD;
                end
            end
            ST_DP_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_DP_EMIT;
            end
            ST_DP_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_elem = 1'b1;
                    cmd.idx_inc  = 1'b1;
                    state_next   = sts.scan_last ? ST_IDLE : ST_DP_RD;
                end
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_status = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = state_reg == ST_IDLE;

endmodule
